>>> sv/pcq_pkg.sv
// ----------------------------------------------------------------------------
// pcq_pkg: shared types and constants for the per-class ring queues
// Command and status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package pcq_pkg;

  // parameter defaults
  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam int NUM_PORTS_DEF    = 16;
  localparam int NUM_CLASSES_DEF  = 256;
  localparam int RECORD_WIDTH_DEF = 64;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int PORT_W   = 4;
  localparam int CLASS_W  = 8;
  localparam int STATUS_W = 3;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_OVERWROTE = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_RESP
  } bk_state_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_t cmd;
    logic in_range;
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

endpackage

>>> sv/pcq_ram.sv
// ----------------------------------------------------------------------------
// pcq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (held when idle).
// ----------------------------------------------------------------------------
module pcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/pcq_fifo.sv
// ----------------------------------------------------------------------------
// pcq_fifo: two-entry command queue between front and back
// Lets the front keep accepting while the back works or waits on output.
// ----------------------------------------------------------------------------
module pcq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] buf_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = buf_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop)  rptr_r <= ~rptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

endmodule

>>> sv/pcq_front.sv
// ----------------------------------------------------------------------------
// pcq_front: command intake and classification
// Range-checks port and class, forms queue index and record base address.
// ----------------------------------------------------------------------------
module pcq_front import pcq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int NUM_PORTS    = NUM_PORTS_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int RECORD_WIDTH = RECORD_WIDTH_DEF,
  localparam int NUM_QUEUES  = NUM_PORTS * NUM_CLASSES,
  localparam int Q_W         = $clog2(NUM_QUEUES),
  localparam int RA_W        = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [PORT_W-1:0]       in_port,
  input  logic [CLASS_W-1:0]      in_class_id,
  input  logic [RECORD_WIDTH-1:0] in_record_in,
  input  logic                    clearing,
  input  logic                    fifo_ready,
  output logic                    push_valid,
  output cmd_ctl_t                push_ctl,
  output logic [Q_W-1:0]          push_q,
  output logic [RA_W-1:0]         push_base,
  output logic [RECORD_WIDTH-1:0] push_rec
);

  logic [31:0] q_full;
  logic [31:0] base_full;

  // no intake while the pointer table is being initialized
  assign in_ready   = fifo_ready && !clearing;
  assign push_valid = in_valid && in_ready;

  // queue index = port * classes + class; base = index * depth
  assign q_full    = 32'(in_port) * 32'(NUM_CLASSES) + 32'(in_class_id);
  assign base_full = q_full * 32'(QUEUE_DEPTH);

  assign push_ctl.cmd      = cmd_t'(in_command);
  assign push_ctl.in_range = (32'(in_port) < 32'(NUM_PORTS)) &&
                             (32'(in_class_id) < 32'(NUM_CLASSES));
  assign push_q    = q_full[Q_W-1:0];
  assign push_base = base_full[RA_W-1:0];
  assign push_rec  = in_record_in;

endmodule

>>> sv/pcq_back.sv
// ----------------------------------------------------------------------------
// pcq_back: command execution on the pointer table and record store
// Sequencer: read queue pointers, update them and touch the record store,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module pcq_back import pcq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int NUM_PORTS    = NUM_PORTS_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int RECORD_WIDTH = RECORD_WIDTH_DEF,
  localparam int NUM_QUEUES  = NUM_PORTS * NUM_CLASSES,
  localparam int Q_W         = $clog2(NUM_QUEUES),
  localparam int RA_W        = $clog2(NUM_QUEUES * QUEUE_DEPTH),
  localparam int PTR_W       = $clog2(QUEUE_DEPTH),
  localparam int M_W         = 2 * PTR_W + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ow_en,
  input  logic                    fifo_valid,
  output logic                    fifo_pop,
  input  cmd_ctl_t                fifo_ctl,
  input  logic [Q_W-1:0]          fifo_q,
  input  logic [RA_W-1:0]         fifo_base,
  input  logic [RECORD_WIDTH-1:0] fifo_rec,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [RECORD_WIDTH-1:0] out_record_out
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [Q_W-1:0]   Q_LAST   = Q_W'(NUM_QUEUES - 1);

  // ring increment
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  bk_state_t               state_r, state_nxt;
  logic [Q_W-1:0]          clr_cnt_r;
  cmd_ctl_t                cur_ctl_r;
  logic [Q_W-1:0]          cur_q_r;
  logic [RA_W-1:0]         cur_base_r;
  logic [RECORD_WIDTH-1:0] cur_rec_r;
  status_t                 res_status_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [RECORD_WIDTH-1:0] out_rec_r;

  logic                    meta_re, meta_we;
  logic [Q_W-1:0]          meta_waddr;
  logic [M_W-1:0]          meta_wdata, meta_rdata;
  logic                    rec_re, rec_we;
  logic [PTR_W-1:0]        rec_ptr;
  logic [RA_W-1:0]         rec_addr;
  logic [RECORD_WIDTH-1:0] rec_rdata;

  logic                    load_cur, load_res, load_out;
  status_t                 exec_status;
  logic                    m_seen;
  logic [PTR_W-1:0]        m_wp, m_rp, wp_next, rp_next;
  logic                    q_full;

  // pointer table word: {seen, write pointer, read pointer}
  assign m_seen  = meta_rdata[M_W-1];
  assign m_wp    = meta_rdata[2*PTR_W-1:PTR_W];
  assign m_rp    = meta_rdata[PTR_W-1:0];
  assign wp_next = ring_next(m_wp);
  assign rp_next = ring_next(m_rp);
  assign q_full  = (wp_next == m_rp);

  assign rec_addr = cur_base_r + RA_W'(rec_ptr);

  pcq_ram #(.WIDTH(M_W), .DEPTH(NUM_QUEUES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (fifo_q),
    .rdata (meta_rdata)
  );

  pcq_ram #(.WIDTH(RECORD_WIDTH), .DEPTH(NUM_QUEUES * QUEUE_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_addr),
    .wdata (cur_rec_r),
    .re    (rec_re),
    .raddr (rec_addr),
    .rdata (rec_rdata)
  );

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (load_out)            out_valid_r <= 1'b1;
      else if (out_ready)      out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_ctl_r  <= fifo_ctl;
      cur_q_r    <= fifo_q;
      cur_base_r <= fifo_base;
      cur_rec_r  <= fifo_rec;
    end
    if (load_res) res_status_r <= exec_status;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_rec_r    <= (res_status_r == ST_POPPED) ? rec_rdata : '0;
    end
  end

  // next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    fifo_pop    = 1'b0;
    load_cur    = 1'b0;
    load_res    = 1'b0;
    load_out    = 1'b0;
    meta_re     = 1'b0;
    meta_we     = 1'b0;
    meta_waddr  = cur_q_r;
    meta_wdata  = meta_rdata;
    rec_we      = 1'b0;
    rec_re      = 1'b0;
    rec_ptr     = wp_next;
    exec_status = ST_EMPTY;
    case (state_r)
      // initialization sweep: every queue unknown, pointers at last slot
      BK_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_r;
        meta_wdata = {1'b0, PTR_LAST, PTR_LAST};
        if (clr_cnt_r == Q_LAST) state_nxt = BK_IDLE;
      end
      // take next command, fetch its pointers
      BK_IDLE: begin
        if (fifo_valid) begin
          fifo_pop  = 1'b1;
          load_cur  = 1'b1;
          meta_re   = fifo_ctl.in_range;
          state_nxt = BK_EXEC;
        end
      end
      // pointer update and record store access
      BK_EXEC: begin
        load_res  = 1'b1;
        state_nxt = BK_RESP;
        if (cur_ctl_r.in_range) begin
          case (cur_ctl_r.cmd)
            CMD_PUSH: begin
              meta_we = 1'b1;
              if (q_full && !ow_en) begin
                exec_status = ST_DROPPED;
                meta_wdata  = {1'b1, m_wp, m_rp};
              end else begin
                rec_we      = 1'b1;
                rec_ptr     = wp_next;
                meta_wdata  = {1'b1, wp_next, q_full ? rp_next : m_rp};
                exec_status = q_full ? ST_OVERWROTE : ST_STORED;
              end
            end
            CMD_POP: begin
              if (m_seen && (m_rp != m_wp)) begin
                meta_we     = 1'b1;
                meta_wdata  = {1'b1, m_wp, rp_next};
                rec_re      = 1'b1;
                rec_ptr     = rp_next;
                exec_status = ST_POPPED;
              end
            end
            CMD_CLEAR: begin
              if (m_seen) begin
                meta_we     = 1'b1;
                meta_wdata  = {1'b1, PTR_LAST, PTR_LAST};
                exec_status = ST_CLEARED;
              end
            end
            default: ;
          endcase
        end
      end
      // wait for the output register
      BK_RESP: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign clearing       = (state_r == BK_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_record_out = out_rec_r;

  // checks
  a_no_rec_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> (!rec_we && !rec_re))
    else $error("record store accessed during init sweep");

  a_rec_write_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    rec_we |-> (exec_status == ST_STORED || exec_status == ST_OVERWROTE))
    else $error("record written without a store status");

  a_out_of_range_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC && !cur_ctl_r.in_range) |-> (!meta_we && !rec_we))
    else $error("state changed for out-of-range queue");

  a_pop_reaches_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC && exec_status == ST_POPPED) |=>
      (state_r == BK_RESP && res_status_r == ST_POPPED))
    else $error("pop result lost before response");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result loaded but not presented");

endmodule

>>> sv/per_class_overwrite_ring_queues_top.sv
// ----------------------------------------------------------------------------
// per_class_overwrite_ring_queues_top: ring queues per (port, class)
// Push, pop and clear on one small ring queue per port and message class,
// with overwrite-oldest or drop on a full queue.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     command, port, class_id, record_in
//   out      output     out_valid/out_ready   status, record_out
//   cfg      input      cfg_wr_en             cfg_wr_data (overwrite_enable)
//
// In the back-end sequencer each command goes through pointer table read,
// pointer update with record store access, and result hand-off to the output.
// A two-entry queue lets the front accept while the back works or stalls.
// After reset the pointer table is initialized, one queue per cycle, across
// all NUM_PORTS*NUM_CLASSES queues (4096 by default); in_ready is low meanwhile.
// Configuration writes are taken in any cycle, including during that sweep.
// ----------------------------------------------------------------------------
module per_class_overwrite_ring_queues_top import pcq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int NUM_PORTS    = NUM_PORTS_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int RECORD_WIDTH = RECORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [PORT_W-1:0]       in_port,
  input  logic [CLASS_W-1:0]      in_class_id,
  input  logic [RECORD_WIDTH-1:0] in_record_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [RECORD_WIDTH-1:0] out_record_out,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data
);

  localparam int NUM_QUEUES = NUM_PORTS * NUM_CLASSES;
  localparam int Q_W        = $clog2(NUM_QUEUES);
  localparam int RA_W       = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int FIFO_W     = CTL_W + Q_W + RA_W + RECORD_WIDTH;

  logic                    ow_en_r;
  logic                    clearing;
  logic                    fifo_ready, push_valid;
  cmd_ctl_t                push_ctl;
  logic [Q_W-1:0]          push_q;
  logic [RA_W-1:0]         push_base;
  logic [RECORD_WIDTH-1:0] push_rec;
  logic                    fifo_valid, fifo_pop;
  logic [FIFO_W-1:0]       fifo_data;
  cmd_ctl_t                fifo_ctl;
  logic [Q_W-1:0]          fifo_q;
  logic [RA_W-1:0]         fifo_base;
  logic [RECORD_WIDTH-1:0] fifo_rec;

  // overwrite_enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ow_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      ow_en_r <= cfg_wr_data;
    end
  end

  pcq_front #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .NUM_PORTS    (NUM_PORTS),
    .NUM_CLASSES  (NUM_CLASSES),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_port      (in_port),
    .in_class_id  (in_class_id),
    .in_record_in (in_record_in),
    .clearing     (clearing),
    .fifo_ready   (fifo_ready),
    .push_valid   (push_valid),
    .push_ctl     (push_ctl),
    .push_q       (push_q),
    .push_base    (push_base),
    .push_rec     (push_rec)
  );

  pcq_fifo #(.WIDTH(FIFO_W)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (fifo_ready),
    .push_data  ({push_ctl, push_q, push_base, push_rec}),
    .pop_valid  (fifo_valid),
    .pop_ready  (fifo_pop),
    .pop_data   (fifo_data)
  );

  assign {fifo_ctl, fifo_q, fifo_base, fifo_rec} = fifo_data;

  pcq_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .NUM_PORTS    (NUM_PORTS),
    .NUM_CLASSES  (NUM_CLASSES),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ow_en          (ow_en_r),
    .fifo_valid     (fifo_valid),
    .fifo_pop       (fifo_pop),
    .fifo_ctl       (fifo_ctl),
    .fifo_q         (fifo_q),
    .fifo_base      (fifo_base),
    .fifo_rec       (fifo_rec),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_record_out (out_record_out)
  );

endmodule
